FILE: rtl/core/mpd_pkg.sv
// Shared types and constants for the MQTT packet deframer.
package mpd_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned MAX_PKT_W  = 16;
  localparam logic [MAX_PKT_W-1:0] MAX_PKT_RESET = 16'd128;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LENGTH  = 3'd1,
    PH_TLEN_HI = 3'd2,
    PH_TLEN_LO = 3'd3,
    PH_TOPIC   = 3'd4,
    PH_MID_HI  = 3'd5,
    PH_MID_LO  = 3'd6,
    PH_BODY    = 3'd7
  } phase_e;

  localparam logic [2:0] REGION_HEADER = 3'd0;
  localparam logic [2:0] REGION_LENGTH = 3'd1;
  localparam logic [2:0] REGION_TLEN   = 3'd2;
  localparam logic [2:0] REGION_TOPIC  = 3'd3;
  localparam logic [2:0] REGION_MID    = 3'd4;
  localparam logic [2:0] REGION_PAYLD  = 3'd5;
  localparam logic [2:0] REGION_OTHER  = 3'd6;
  localparam logic [2:0] REGION_NONE   = 3'd7;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_LONG    = 2'd1;
  localparam logic [1:0] STATUS_BAD     = 2'd2;
  localparam logic [1:0] STATUS_ABORTED = 2'd3;

  localparam logic [1:0] REPLY_NONE      = 2'd0;
  localparam logic [1:0] REPLY_PUBACK    = 2'd1;
  localparam logic [1:0] REPLY_PINGRESP  = 2'd2;
  localparam logic [1:0] REPLY_PINGCLEAR = 2'd3;

  localparam logic [3:0] KIND_PUBLISH  = 4'd3;
  localparam logic [3:0] KIND_PINGREQ  = 4'd12;
  localparam logic [3:0] KIND_PINGRESP = 4'd13;

  localparam logic [1:0] QOS_INVALID = 2'd3;

  localparam int unsigned ERR_LONG_BIT = 0;
  localparam int unsigned ERR_BAD_BIT  = 1;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  region;
    logic [3:0]  packet_kind;
    logic [2:0]  length_field_bytes;
    logic [27:0] remaining_length;
    logic [15:0] topic_length;
    logic [15:0] message_id;
    logic        packet_end;
    logic [1:0]  status;
    logic [1:0]  reply_action;
  } result_t;

endpackage

FILE: rtl/core/mpd_apb_regs.sv
// APB configuration register: maximum packet size.
module mpd_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mpd_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mpd_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mpd_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  output logic [mpd_pkg::MAX_PKT_W-1:0]       max_pkt_o
);

  logic [mpd_pkg::MAX_PKT_W-1:0] max_pkt_q;
  logic                          sel_max;
  logic                          wr_en;

  // word index 0 is the only register
  assign sel_max = (paddr[2] == 1'b0);
  assign wr_en   = psel && penable && pwrite && sel_max;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pkt_q <= mpd_pkg::MAX_PKT_RESET;
    end else if (wr_en) begin
      max_pkt_q <= pwdata[mpd_pkg::MAX_PKT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_max) begin
      prdata[mpd_pkg::MAX_PKT_W-1:0] = max_pkt_q;
    end
  end

  assign max_pkt_o = max_pkt_q;

endmodule

FILE: rtl/core/mpd_parser.sv
// Parser state and per-byte tagging logic.
module mpd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          proc_i,
  input  logic [7:0]                    byte_i,
  input  logic                          abort_i,
  input  logic [mpd_pkg::MAX_PKT_W-1:0] max_pkt_i,
  output mpd_pkg::result_t              res_o
);

  mpd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  kind_q,  kind_d;
  logic [1:0]  qos_q,   qos_d;
  logic [27:0] accum_q, accum_d;
  logic [2:0]  cnt_q,   cnt_d;
  logic [27:0] left_q,  left_d;
  logic [15:0] tlen_q,  tlen_d;
  logic [15:0] tleft_q, tleft_d;
  logic [15:0] mid_q,   mid_d;
  logic [1:0]  err_q,   err_d;

  logic [27:0] add_val;
  logic [28:0] whole;
  logic        is_pub;
  logic        has_mid;
  logic        pkt_end;
  logic        bad;
  logic [2:0]  region;
  logic [1:0]  status;
  logic [1:0]  reply;

  assign is_pub  = (kind_q == mpd_pkg::KIND_PUBLISH);
  assign has_mid = (qos_q == 2'd1) || (qos_q == 2'd2);

  always_comb begin
    case (cnt_q[1:0])
      2'd0:    add_val = {21'd0, byte_i[6:0]};
      2'd1:    add_val = {14'd0, byte_i[6:0], 7'd0};
      2'd2:    add_val = {7'd0, byte_i[6:0], 14'd0};
      default: add_val = {byte_i[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    kind_d  = kind_q;
    qos_d   = qos_q;
    accum_d = accum_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    tlen_d  = tlen_q;
    tleft_d = tleft_q;
    mid_d   = mid_q;
    err_d   = err_q;
    region  = mpd_pkg::REGION_NONE;
    pkt_end = 1'b0;
    status  = mpd_pkg::STATUS_OK;
    reply   = mpd_pkg::REPLY_NONE;
    bad     = 1'b0;
    whole   = '0;

    case (phase_q)
      mpd_pkg::PH_HEADER: begin
        kind_d  = byte_i[7:4];
        qos_d   = byte_i[2:1];
        accum_d = '0;
        cnt_d   = '0;
        left_d  = '0;
        tlen_d  = '0;
        tleft_d = '0;
        mid_d   = '0;
        err_d   = '0;
        phase_d = mpd_pkg::PH_LENGTH;
        region  = mpd_pkg::REGION_HEADER;
      end
      mpd_pkg::PH_LENGTH: begin
        region = mpd_pkg::REGION_LENGTH;
        if (!cnt_q[2]) begin
          accum_d = accum_q + add_val;
        end
        cnt_d = cnt_q + 3'd1;
        if (byte_i[7]) begin
          if (cnt_d >= 3'd4) begin
            err_d[mpd_pkg::ERR_BAD_BIT] = 1'b1;
            pkt_end = 1'b1;
          end
        end else begin
          // header byte plus length bytes plus body
          whole = {1'b0, accum_d} + {26'd0, cnt_d} + 29'd1;
          if (whole > {13'd0, max_pkt_i}) begin
            err_d[mpd_pkg::ERR_LONG_BIT] = 1'b1;
          end
          left_d  = accum_d;
          phase_d = is_pub ? mpd_pkg::PH_TLEN_HI : mpd_pkg::PH_BODY;
          if (accum_d == '0) begin
            pkt_end = 1'b1;
          end
        end
      end
      default: begin
        if (left_q != '0) begin
          left_d = left_q - 28'd1;
        end
        case (phase_q)
          mpd_pkg::PH_TLEN_HI: begin
            region  = mpd_pkg::REGION_TLEN;
            tlen_d  = {byte_i, 8'd0};
            phase_d = mpd_pkg::PH_TLEN_LO;
          end
          mpd_pkg::PH_TLEN_LO: begin
            region  = mpd_pkg::REGION_TLEN;
            tlen_d  = {tlen_q[15:8], byte_i};
            tleft_d = tlen_d;
            if (tlen_d != '0) begin
              phase_d = mpd_pkg::PH_TOPIC;
            end else begin
              phase_d = has_mid ? mpd_pkg::PH_MID_HI : mpd_pkg::PH_BODY;
            end
          end
          mpd_pkg::PH_TOPIC: begin
            region = mpd_pkg::REGION_TOPIC;
            if (tleft_q != '0) begin
              tleft_d = tleft_q - 16'd1;
            end
            if (tleft_d == '0) begin
              phase_d = has_mid ? mpd_pkg::PH_MID_HI : mpd_pkg::PH_BODY;
            end
          end
          mpd_pkg::PH_MID_HI: begin
            region  = mpd_pkg::REGION_MID;
            mid_d   = {byte_i, 8'd0};
            phase_d = mpd_pkg::PH_MID_LO;
          end
          mpd_pkg::PH_MID_LO: begin
            region  = mpd_pkg::REGION_MID;
            mid_d   = {mid_q[15:8], byte_i};
            phase_d = mpd_pkg::PH_BODY;
          end
          default: begin
            region = is_pub ? mpd_pkg::REGION_PAYLD : mpd_pkg::REGION_OTHER;
          end
        endcase
        if (left_d == '0) begin
          pkt_end = 1'b1;
        end
      end
    endcase

    // end of packet: status and reply
    if (pkt_end) begin
      bad = err_d[mpd_pkg::ERR_BAD_BIT]
          || (is_pub && (phase_d != mpd_pkg::PH_BODY))
          || (is_pub && (qos_q == mpd_pkg::QOS_INVALID));
      err_d[mpd_pkg::ERR_BAD_BIT] = bad;
      if (bad) begin
        status = mpd_pkg::STATUS_BAD;
      end else if (err_d[mpd_pkg::ERR_LONG_BIT]) begin
        status = mpd_pkg::STATUS_LONG;
      end else if (is_pub && (qos_q == 2'd1)) begin
        reply = mpd_pkg::REPLY_PUBACK;
      end else if (kind_q == mpd_pkg::KIND_PINGREQ) begin
        reply = mpd_pkg::REPLY_PINGRESP;
      end else if (kind_q == mpd_pkg::KIND_PINGRESP) begin
        reply = mpd_pkg::REPLY_PINGCLEAR;
      end
      phase_d = mpd_pkg::PH_HEADER;
    end

    if (abort_i) begin
      res_o.data_byte          = '0;
      res_o.region             = mpd_pkg::REGION_NONE;
      res_o.packet_kind        = kind_q;
      res_o.length_field_bytes = cnt_q;
      res_o.remaining_length   = accum_q;
      res_o.topic_length       = tlen_q;
      res_o.message_id         = mid_q;
      res_o.packet_end         = 1'b1;
      res_o.status             = mpd_pkg::STATUS_ABORTED;
      res_o.reply_action       = mpd_pkg::REPLY_NONE;
      phase_d = mpd_pkg::PH_HEADER;
      kind_d  = '0;
      qos_d   = '0;
      accum_d = '0;
      cnt_d   = '0;
      left_d  = '0;
      tlen_d  = '0;
      tleft_d = '0;
      mid_d   = '0;
      err_d   = '0;
    end else begin
      res_o.data_byte          = byte_i;
      res_o.region             = region;
      res_o.packet_kind        = kind_d;
      res_o.length_field_bytes = cnt_d;
      res_o.remaining_length   = accum_d;
      res_o.topic_length       = tlen_d;
      res_o.message_id         = mid_d;
      res_o.packet_end         = pkt_end;
      res_o.status             = status;
      res_o.reply_action       = reply;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mpd_pkg::PH_HEADER;
      kind_q  <= '0;
      qos_q   <= '0;
      accum_q <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      tlen_q  <= '0;
      tleft_q <= '0;
      mid_q   <= '0;
      err_q   <= '0;
    end else if (proc_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      qos_q   <= qos_d;
      accum_q <= accum_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      tlen_q  <= tlen_d;
      tleft_q <= tleft_d;
      mid_q   <= mid_d;
      err_q   <= err_d;
    end
  end

endmodule

FILE: rtl/core/mqtt_packet_deframer_core.sv
// Top level of the MQTT packet deframer: input register, parser, result register.
// Takes one received byte per clock unless stalled and returns one tagged result
// per byte, in order. A byte is registered in the input register on acceptance,
// then parsed and its result written to the output register once the output is
// not stalled; sustained rate is one byte per cycle while the output does not
// stall. The max_packet_bytes register sits at byte address 0 of the APB port
// and should be written only while no byte is in flight.
module mqtt_packet_deframer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           abort_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     data_byte_o,
  output logic [2:0]                     region_o,
  output logic [3:0]                     packet_kind_o,
  output logic [2:0]                     length_field_bytes_o,
  output logic [27:0]                    remaining_length_o,
  output logic [15:0]                    topic_length_o,
  output logic [15:0]                    message_id_o,
  output logic                           packet_end_o,
  output logic [1:0]                     status_o,
  output logic [1:0]                     reply_action_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mpd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  logic                          in_vld_q;
  logic [7:0]                    in_byte_q;
  logic                          in_abort_q;
  logic                          out_vld_q;
  mpd_pkg::result_t              res;
  mpd_pkg::result_t              out_q;
  logic                          adv;
  logic [mpd_pkg::MAX_PKT_W-1:0] max_pkt;

  mpd_apb_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_pkt_o (max_pkt)
  );

  mpd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (adv),
    .byte_i    (in_byte_q),
    .abort_i   (in_abort_q),
    .max_pkt_i (max_pkt),
    .res_o     (res)
  );

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= rx_byte_i;
      in_abort_q <= abort_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_vld_q;
  assign data_byte_o          = out_q.data_byte;
  assign region_o             = out_q.region;
  assign packet_kind_o        = out_q.packet_kind;
  assign length_field_bytes_o = out_q.length_field_bytes;
  assign remaining_length_o   = out_q.remaining_length;
  assign topic_length_o       = out_q.topic_length;
  assign message_id_o         = out_q.message_id;
  assign packet_end_o         = out_q.packet_end;
  assign status_o             = out_q.status;
  assign reply_action_o       = out_q.reply_action;

endmodule
